// ===== design/mmm_pkg.sv =====
// Shared types and constants of the radix 2^52 modular multiplier.
// Holds limb, counter and multiplier request/response types, input action codes
// and configuration register indexes. No dependencies.
package mmm_pkg;

    localparam int LIMB_W  = 52;
    localparam int HALF_W  = 26;
    localparam int PROD_W  = 2 * LIMB_W;
    localparam int CNT_W   = 7;
    localparam int CARRY_W = LIMB_W + 1;

    typedef logic [LIMB_W-1:0]  limb_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [CARRY_W-1:0] carry_t;
    typedef logic [1:0]         action_t;
    typedef logic [1:0]         cfg_idx_t;

    localparam action_t ACT_LOAD_N = 2'd0;
    localparam action_t ACT_LOAD_A = 2'd1;
    localparam action_t ACT_LOAD_B = 2'd2;
    localparam action_t ACT_START  = 2'd3;

    localparam cfg_idx_t CFG_FIELD_MODE  = 2'd0;
    localparam cfg_idx_t CFG_LIMB_COUNT  = 2'd1;
    localparam cfg_idx_t CFG_NEG_INVERSE = 2'd2;
    localparam cfg_idx_t CFG_FOLD_SHIFT  = 2'd3;

    typedef struct packed {
        logic  start;
        limb_t x;
        limb_t y;
    } mul_req_t;

    typedef struct packed {
        logic  done;
        prod_t prod;
    } mul_rsp_t;

endpackage

// ===== design/mmm_ram.sv =====
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module mmm_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mmm_mul.sv =====
// Iterative 52 x 52 multiplier: one 26 x 26 partial product per cycle while busy.
// Depends on mmm_pkg for the request and response types.
module mmm_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  mmm_pkg::mul_req_t req,
    output mmm_pkg::mul_rsp_t rsp
);
    import mmm_pkg::*;

    limb_t               x_reg;
    limb_t               y_reg;
    logic [2:0]          step_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [LIMB_W-1:0]   pp_reg;
    prod_t               acc_reg;
    logic [HALF_W-1:0]   xs;
    logic [HALF_W-1:0]   ys;
    logic [LIMB_W-1:0]   pp_next;
    prod_t               addend;

    always_comb
    begin
        xs = step_reg[1] ? x_reg[LIMB_W-1:HALF_W] : x_reg[HALF_W-1:0];
        ys = step_reg[0] ? y_reg[LIMB_W-1:HALF_W] : y_reg[HALF_W-1:0];
        pp_next = LIMB_W'(xs) * LIMB_W'(ys);
        // shift of the partial product taken in the previous step
        case (step_reg) inside
            3'd1:       addend = PROD_W'(pp_reg);
            3'd2, 3'd3: addend = PROD_W'(pp_reg) << HALF_W;
            3'd4:       addend = PROD_W'(pp_reg) << LIMB_W;
            default:    addend = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= req.x;
            y_reg   <= req.y;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            pp_reg  <= pp_next;
            acc_reg <= acc_reg + addend;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

// ===== design/modular_multiplier_montgomery_mersenne_unit.sv =====
// Top level of the radix 2^52 modular multiplier: limb stores, column store,
// sequencer and the add/subtract datapath around the shared multiplier.
// Depends on mmm_pkg, mmm_ram and mmm_mul.
//
// Usage:
//   Load the modulus and operands one limb per item transfer (action 0, 1, 2
//   with limb_index and limb_value); loads may follow back to back. An item
//   with action 3 starts the multiply over n = limb_count limbs and the
//   block then returns n result transfers, least significant limb first,
//   last_limb high on limb n-1. item_ready is low from the start transfer
//   until the last result limb is taken. Configuration writes on
//   cfg_write/cfg_index/cfg_data must only happen while the block is idle.
//   Sequence: the start clears 2n+2 columns first. Montgomery mode then runs
//   n rows and a final compare; Mersenne mode runs n rows, then folding
//   passes (normally two or three, the last one finding nothing at or above
//   bit k) and a compare. Each result limb is then read, computed and held
//   until it is taken.
//   Reset clears the configuration to Montgomery mode, one limb, and leaves
//   the limb stores undefined until written.
//   When the receiver stalls, hold the current result limb and wait; each
//   limb is built only after the previous one is transferred.
module modular_multiplier_montgomery_mersenne_unit #(
    parameter int MAX_LIMBS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  mmm_pkg::cfg_idx_t cfg_index,
    input  mmm_pkg::limb_t    cfg_data,
    input  logic              item_valid,
    output logic              item_ready,
    input  mmm_pkg::action_t  action,
    input  logic [4:0]        limb_index,
    input  mmm_pkg::limb_t    limb_value,
    output logic              result_valid,
    input  logic              result_ready,
    output mmm_pkg::limb_t    result_limb,
    output logic [4:0]        result_index,
    output logic              last_limb
);
    import mmm_pkg::*;

    localparam int AW        = $clog2(MAX_LIMBS);
    localparam int ACC_DEPTH = 2 * MAX_LIMBS + 2;
    localparam int CW        = $clog2(ACC_DEPTH);
    localparam int CAP       = (MAX_LIMBS < 32) ? MAX_LIMBS : 32;
    localparam cnt_t CNT_ONE = cnt_t'(1);
    localparam cnt_t CNT_TWO = cnt_t'(2);

    typedef enum logic [21:0] {
        S_IDLE     = 22'h000001,
        S_CLEAR    = 22'h000002,
        S_ROW_RD   = 22'h000004,
        S_ROW_LAT  = 22'h000008,
        S_MAC_RD   = 22'h000010,
        S_MAC_MUL  = 22'h000020,
        S_MAC_WAIT = 22'h000040,
        S_PASS_END = 22'h000080,
        S_M_RD     = 22'h000100,
        S_M_MUL    = 22'h000200,
        S_M_WAIT   = 22'h000400,
        S_FOLD_R0  = 22'h000800,
        S_FOLD_R1  = 22'h001000,
        S_FOLD_R2  = 22'h002000,
        S_FOLD_ADD = 22'h004000,
        S_CMP_RD   = 22'h008000,
        S_CMP_CHK  = 22'h010000,
        S_TOP_RD   = 22'h020000,
        S_TOP_CHK  = 22'h040000,
        S_OUT_RD   = 22'h080000,
        S_OUT_CALC = 22'h100000,
        S_OUT_WAIT = 22'h200000
    } state_t;

    typedef enum logic [1:0] {
        PH_MONT_A = 2'd0,   // add a*b[i] into the columns
        PH_MONT_B = 2'd1,   // add m*N and drop one limb
        PH_PROD   = 2'd2    // schoolbook product row
    } phase_t;

    // configuration
    logic       field_mode_reg;
    logic [5:0] limb_count_reg;
    limb_t      neg_inv_reg;
    logic [5:0] fold_shift_reg;

    // sequencer state
    state_t state_reg,  state_next;
    phase_t phase_reg,  phase_next;
    cnt_t   n_reg,      n_next;
    cnt_t   row_reg,    row_next;
    cnt_t   j_reg,      j_next;
    carry_t carry_reg,  carry_next;
    limb_t  y_reg,      y_next;
    limb_t  col_reg,    col_next;
    limb_t  low_reg,    low_next;
    limb_t  h0_reg,     h0_next;
    logic   any_reg,    any_next;
    logic   borrow_reg, borrow_next;
    logic   sel_reg,    sel_next;
    logic   valid_reg,  valid_next;
    limb_t  limb_reg,   limb_next;
    logic [4:0] index_reg, index_next;
    logic   last_reg,   last_next;

    // memories
    logic  st_we_n, st_we_a, st_we_b;
    logic [AW-1:0] st_waddr;
    cnt_t  st_raddr_c;
    limb_t n_q, a_q, b_q, x_q;
    logic  acc_we;
    cnt_t  acc_waddr_c, acc_raddr_c;
    limb_t acc_wdata, acc_q;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    // derived values
    logic [5:0] n_cfg, sh_sat, r_c;
    cnt_t  q_c, len_c, plen_c, base_c;
    logic  last_j, load_ok;
    limb_t prod_lo, prod_hi;
    logic [LIMB_W+1:0] mac_sum;
    limb_t h1, fold_h, fold_low, low_mask;
    logic [LIMB_W:0] fold_sum, sub_diff;

    assign item_ready = (state_reg == S_IDLE);

    // store writes: drop loads beyond the store depth
    assign load_ok  = item_valid && item_ready && (action != ACT_START)
                      && (32'(limb_index) < MAX_LIMBS);
    assign st_we_n  = load_ok && (action == ACT_LOAD_N);
    assign st_we_a  = load_ok && (action == ACT_LOAD_A);
    assign st_we_b  = load_ok && (action == ACT_LOAD_B);
    assign st_waddr = AW'(limb_index);

    mmm_ram #(.WIDTH(LIMB_W), .DEPTH(MAX_LIMBS)) u_ram_n (
        .clk(clk), .we(st_we_n), .waddr(st_waddr), .wdata(limb_value),
        .raddr(AW'(st_raddr_c)), .rdata(n_q)
    );
    mmm_ram #(.WIDTH(LIMB_W), .DEPTH(MAX_LIMBS)) u_ram_a (
        .clk(clk), .we(st_we_a), .waddr(st_waddr), .wdata(limb_value),
        .raddr(AW'(st_raddr_c)), .rdata(a_q)
    );
    mmm_ram #(.WIDTH(LIMB_W), .DEPTH(MAX_LIMBS)) u_ram_b (
        .clk(clk), .we(st_we_b), .waddr(st_waddr), .wdata(limb_value),
        .raddr(AW'(st_raddr_c)), .rdata(b_q)
    );
    mmm_ram #(.WIDTH(LIMB_W), .DEPTH(ACC_DEPTH)) u_ram_acc (
        .clk(clk), .we(acc_we), .waddr(CW'(acc_waddr_c)), .wdata(acc_wdata),
        .raddr(CW'(acc_raddr_c)), .rdata(acc_q)
    );

    mmm_mul u_mul (
        .clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp)
    );

    // limb count 0 counts as one, large values saturate
    always_comb
    begin
        if (limb_count_reg == 6'd0)
            n_cfg = 6'd1;
        else if (limb_count_reg > 6'(CAP))
            n_cfg = 6'(CAP);
        else
            n_cfg = limb_count_reg;
    end

    // k = 52n - shift splits into limb q and bit r without a divider
    assign sh_sat = (fold_shift_reg > 6'd51) ? 6'd51 : fold_shift_reg;
    assign q_c    = (sh_sat == 6'd0) ? n_reg : n_reg - CNT_ONE;
    assign r_c    = (sh_sat == 6'd0) ? 6'd0 : 6'(LIMB_W) - sh_sat;
    assign len_c  = (n_reg << 1) + CNT_ONE;
    assign plen_c = (phase_reg == PH_PROD) ? n_reg + CNT_ONE : n_reg + CNT_TWO;
    assign base_c = (phase_reg == PH_PROD) ? row_reg : '0;
    assign last_j = (j_reg == n_reg - CNT_ONE);

    always_comb
    begin
        case (phase_reg)
            PH_MONT_A: x_q = a_q;
            PH_MONT_B: x_q = n_q;
            default:   x_q = b_q;
        endcase
    end

    // column step: column + product low + carry
    assign prod_lo = mul_rsp.prod[LIMB_W-1:0];
    assign prod_hi = mul_rsp.prod[PROD_W-1:LIMB_W];
    assign mac_sum = {2'b00, col_reg} + {2'b00, prod_lo} + {1'b0, carry_reg};

    // fold step: low part below bit k plus the bits at and above k
    assign h1 = ((r_c != 6'd0) && ((q_c + j_reg + CNT_ONE) < len_c)) ? acc_q : '0;
    assign fold_h   = (h0_reg >> r_c) | (h1 << (6'(LIMB_W) - r_c));
    assign low_mask = (limb_t'(1) << r_c) - limb_t'(1);
    always_comb
    begin
        if (j_reg < q_c)
            fold_low = low_reg;
        else if (j_reg == q_c)
            fold_low = low_reg & low_mask;
        else
            fold_low = '0;
    end
    assign fold_sum = {1'b0, fold_low} + {1'b0, fold_h} + {{LIMB_W{1'b0}}, carry_reg[0]};

    // limb of x - N with running borrow
    assign sub_diff = {1'b0, acc_q} - {1'b0, n_q} - {{LIMB_W{1'b0}}, borrow_reg};

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        n_next      = n_reg;
        row_next    = row_reg;
        j_next      = j_reg;
        carry_next  = carry_reg;
        y_next      = y_reg;
        col_next    = col_reg;
        low_next    = low_reg;
        h0_next     = h0_reg;
        any_next    = any_reg;
        borrow_next = borrow_reg;
        sel_next    = sel_reg;
        valid_next  = valid_reg;
        limb_next   = limb_reg;
        index_next  = index_reg;
        last_next   = last_reg;
        acc_we      = 1'b0;
        acc_waddr_c = '0;
        acc_wdata   = '0;
        acc_raddr_c = '0;
        st_raddr_c  = '0;
        mul_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && (action == ACT_START))
                begin
                    n_next     = cnt_t'(n_cfg);
                    j_next     = '0;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                acc_we      = 1'b1;
                acc_waddr_c = j_reg;
                if (j_reg == len_c)
                begin
                    row_next   = '0;
                    state_next = S_ROW_RD;
                end
                else
                begin
                    j_next = j_reg + CNT_ONE;
                end
            end
            S_ROW_RD:
            begin
                st_raddr_c = row_reg;
                state_next = S_ROW_LAT;
            end
            S_ROW_LAT:
            begin
                y_next     = field_mode_reg ? a_q : b_q;
                phase_next = field_mode_reg ? PH_PROD : PH_MONT_A;
                j_next     = '0;
                carry_next = '0;
                state_next = S_MAC_RD;
            end
            S_MAC_RD:
            begin
                acc_raddr_c = base_c + j_reg;
                st_raddr_c  = j_reg;
                state_next  = S_MAC_MUL;
            end
            S_MAC_MUL:
            begin
                col_next      = acc_q;
                mul_req.start = 1'b1;
                mul_req.x     = (j_reg < n_reg) ? x_q : '0;
                mul_req.y     = y_reg;
                state_next    = S_MAC_WAIT;
            end
            S_MAC_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    carry_next = {1'b0, prod_hi} + carry_t'(mac_sum[LIMB_W+1:LIMB_W]);
                    // the reduction pass writes one column down, dropping column 0
                    acc_we      = (phase_reg != PH_MONT_B) || (j_reg != '0);
                    acc_waddr_c = (phase_reg == PH_MONT_B) ? j_reg - CNT_ONE
                                                           : base_c + j_reg;
                    acc_wdata   = mac_sum[LIMB_W-1:0];
                    if (j_reg == plen_c - CNT_ONE)
                    begin
                        state_next = S_PASS_END;
                    end
                    else
                    begin
                        j_next     = j_reg + CNT_ONE;
                        state_next = S_MAC_RD;
                    end
                end
            end
            S_PASS_END:
            begin
                case (phase_reg)
                    PH_MONT_A:
                    begin
                        state_next = S_M_RD;
                    end
                    PH_MONT_B:
                    begin
                        acc_we      = 1'b1;
                        acc_waddr_c = n_reg + CNT_ONE;
                        row_next    = row_reg + CNT_ONE;
                        if (row_reg == n_reg - CNT_ONE)
                        begin
                            j_next      = '0;
                            borrow_next = 1'b0;
                            state_next  = S_CMP_RD;
                        end
                        else
                        begin
                            state_next = S_ROW_RD;
                        end
                    end
                    default:
                    begin
                        row_next = row_reg + CNT_ONE;
                        if (row_reg == n_reg - CNT_ONE)
                        begin
                            j_next     = '0;
                            carry_next = '0;
                            any_next   = 1'b0;
                            state_next = S_FOLD_R0;
                        end
                        else
                        begin
                            state_next = S_ROW_RD;
                        end
                    end
                endcase
            end
            S_M_RD:
            begin
                acc_raddr_c = '0;
                state_next  = S_M_MUL;
            end
            S_M_MUL:
            begin
                mul_req.start = 1'b1;
                mul_req.x     = acc_q;
                mul_req.y     = neg_inv_reg;
                state_next    = S_M_WAIT;
            end
            S_M_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    y_next     = prod_lo;
                    phase_next = PH_MONT_B;
                    j_next     = '0;
                    carry_next = '0;
                    state_next = S_MAC_RD;
                end
            end
            S_FOLD_R0:
            begin
                acc_raddr_c = j_reg;
                state_next  = S_FOLD_R1;
            end
            S_FOLD_R1:
            begin
                low_next    = acc_q;
                acc_raddr_c = q_c + j_reg;
                state_next  = S_FOLD_R2;
            end
            S_FOLD_R2:
            begin
                h0_next     = ((q_c + j_reg) < len_c) ? acc_q : '0;
                acc_raddr_c = q_c + j_reg + CNT_ONE;
                state_next  = S_FOLD_ADD;
            end
            S_FOLD_ADD:
            begin
                acc_we      = 1'b1;
                acc_waddr_c = j_reg;
                acc_wdata   = fold_sum[LIMB_W-1:0];
                carry_next  = carry_t'(fold_sum[LIMB_W]);
                any_next    = any_reg || (fold_h != '0);
                if (j_reg == len_c - CNT_ONE)
                begin
                    j_next = '0;
                    if (any_reg || (fold_h != '0))
                    begin
                        // something was at or above bit k: fold again
                        carry_next = '0;
                        any_next   = 1'b0;
                        state_next = S_FOLD_R0;
                    end
                    else
                    begin
                        borrow_next = 1'b0;
                        state_next  = S_CMP_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + CNT_ONE;
                    state_next = S_FOLD_R0;
                end
            end
            S_CMP_RD:
            begin
                acc_raddr_c = j_reg;
                st_raddr_c  = j_reg;
                state_next  = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                borrow_next = sub_diff[LIMB_W];
                if (last_j)
                begin
                    j_next = '0;
                    if (!field_mode_reg)
                    begin
                        state_next = S_TOP_RD;
                    end
                    else
                    begin
                        sel_next    = !sub_diff[LIMB_W];
                        borrow_next = 1'b0;
                        state_next  = S_OUT_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + CNT_ONE;
                    state_next = S_CMP_RD;
                end
            end
            S_TOP_RD:
            begin
                acc_raddr_c = n_reg;
                state_next  = S_TOP_CHK;
            end
            S_TOP_CHK:
            begin
                // subtract when the top limb covers the borrow
                sel_next    = !borrow_reg || (acc_q != '0);
                borrow_next = 1'b0;
                state_next  = S_OUT_RD;
            end
            S_OUT_RD:
            begin
                acc_raddr_c = j_reg;
                st_raddr_c  = j_reg;
                state_next  = S_OUT_CALC;
            end
            S_OUT_CALC:
            begin
                borrow_next = sub_diff[LIMB_W];
                limb_next   = sel_reg ? sub_diff[LIMB_W-1:0] : acc_q;
                index_next  = 5'(j_reg);
                last_next   = last_j;
                valid_next  = 1'b1;
                state_next  = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (result_ready)
                begin
                    valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + CNT_ONE;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= 1'b0;
            field_mode_reg <= 1'b0;
            limb_count_reg <= 6'd1;
            neg_inv_reg    <= '0;
            fold_shift_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_FIELD_MODE:  field_mode_reg <= cfg_data[0];
                    CFG_LIMB_COUNT:  limb_count_reg <= cfg_data[5:0];
                    CFG_NEG_INVERSE: neg_inv_reg    <= cfg_data;
                    CFG_FOLD_SHIFT:  fold_shift_reg <= cfg_data[5:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg  <= phase_next;
        n_reg      <= n_next;
        row_reg    <= row_next;
        j_reg      <= j_next;
        carry_reg  <= carry_next;
        y_reg      <= y_next;
        col_reg    <= col_next;
        low_reg    <= low_next;
        h0_reg     <= h0_next;
        any_reg    <= any_next;
        borrow_reg <= borrow_next;
        sel_reg    <= sel_next;
        limb_reg   <= limb_next;
        index_reg  <= index_next;
        last_reg   <= last_next;
    end

    assign result_valid = valid_reg;
    assign result_limb  = limb_reg;
    assign result_index = index_reg;
    assign last_limb    = last_reg;

endmodule
